/* hw/rtl/cgc_pkg.sv */
// Shared types, constants and codes for the coverage grid counter.
// No dependencies; every other RTL file references this package by scope.
`timescale 1ns / 1ps
`default_nettype none

package cgc_pkg;

	localparam int MAX_GRID_SIDE_DEF = 256;
	localparam int MAX_STATIONS_DEF  = 1024;

	// field widths
	localparam int GRID_W   = 9;
	localparam int RADIUS_W = 8;
	localparam int ACT_W    = 2;
	localparam int IDX_W    = 10;
	localparam int XY_W     = 8;
	localparam int COV_W    = 17;
	localparam int USED_W   = 11;
	localparam int CNT_W    = 11;
	// signed coordinate width: covers -255 .. 510
	localparam int CRD_W    = 11;
	// radicand and root of the span square root
	localparam int SQ_W     = 16;
	localparam int ROOT_W   = 8;
	localparam int ROOT_CNT_W = 3;

	localparam logic [CNT_W-1:0] CELL_MAX = 11'd2047;

	// action codes
	localparam logic [ACT_W-1:0] ACT_TOGGLE = 2'd0;
	localparam logic [ACT_W-1:0] ACT_PROBE  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS      = 2'd2;

	localparam logic [GRID_W-1:0]   GRID_SIDE_RST = 9'd256;
	localparam logic [RADIUS_W-1:0] RADIUS_RST    = 8'd1;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [IDX_W-1:0] station_index;
		logic [XY_W-1:0]  station_x;
		logic [XY_W-1:0]  station_y;
	} in_t;

	typedef struct packed {
		logic [COV_W-1:0]  covered_count;
		logic [USED_W-1:0] used_count;
		logic              station_on;
	} out_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DEC,
		S_SDEC,
		S_DX,
		S_SQSTART,
		S_SQWAIT,
		S_CRD,
		S_CWR,
		S_FIN,
		S_CLEAR,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_ZERO,
		RES_TOTALS,
		RES_STATION,
		RES_WALK
	} res_t;

	typedef struct packed {
		logic latch_item;
		logic sweep_we;
		logic clr_tot;
		logic st_rd;
		logic setup;
		logic dx;
		logic sq_start;
		logic rows;
		logic next_col;
		logic cell_rd;
		logic cell_wr;
		logic load_out;
		res_t res_set;
	} cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] act;
		logic idx_ok;
		logic cols_empty;
		logic sq_busy;
		logic rows_empty;
		logic col_last;
		logic row_last;
		logic sweep_last;
	} sts_t;

endpackage

`default_nettype wire

/* hw/rtl/coverage_grid_counter_core.sv */
// Top level of the coverage grid counter: configuration registers, controller,
// datapath and square root unit. Depends on cgc_pkg, cgc_isqrt, cgc_ctrl, cgc_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a per-cell coverage count grid (256 by 256 cells, 11-bit saturating
// counts) plus a selected bit per station site. One item is worked at a time.
// A toggle or probe walks the station's circular footprint column by column: per
// column the squared offset, then a bit-serial square root for the row span, then
// a read-modify-write on the count memory for each cell, plus a station lookup
// before the walk and a finish step after it. A clear item, and the pass right
// after reset, sweep both stores one entry per cycle over max(65536, MaxStations)
// entries, 65536 at the default station count, during which no beat is accepted
// (configuration writes still are). An invalid station index or action 3 returns
// without a footprint walk. Results sit in an output register, so a finished beat
// may wait for the consumer while the block goes idle.
// Configuration is meant to be written only while no item is in flight.
module coverage_grid_counter_core #(
	parameter int MaxStations = cgc_pkg::MAX_STATIONS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire cgc_pkg::in_t                      in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output cgc_pkg::out_t                          out_data,
	input  wire logic                              cfg_we,
	input  wire logic [cgc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [cgc_pkg::GRID_W-1:0]        cfg_wdata
);

	// configuration registers
	logic [cgc_pkg::GRID_W-1:0]   grid_width_q;
	logic [cgc_pkg::GRID_W-1:0]   grid_height_q;
	logic [cgc_pkg::RADIUS_W-1:0] radius_q;

	cgc_pkg::cmd_t               cmd;
	cgc_pkg::sts_t               sts;
	logic                        sq_busy;
	logic [cgc_pkg::ROOT_W-1:0]  sq_root;
	logic [cgc_pkg::SQ_W-1:0]    radicand;

	// an index past the register list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= cgc_pkg::GRID_SIDE_RST;
			grid_height_q <= cgc_pkg::GRID_SIDE_RST;
			radius_q      <= cgc_pkg::RADIUS_RST;
		end else if (cfg_we) begin
			if (cfg_idx == cgc_pkg::CFG_GRID_WIDTH)  grid_width_q  <= cfg_wdata;
			if (cfg_idx == cgc_pkg::CFG_GRID_HEIGHT) grid_height_q <= cfg_wdata;
			if (cfg_idx == cgc_pkg::CFG_RADIUS)
				radius_q <= cfg_wdata[cgc_pkg::RADIUS_W-1:0];
		end
	end

	cgc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// row span per column: floor(sqrt(r*r - dx*dx))
	cgc_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sq_start),
		.radicand (radicand),
		.busy     (sq_busy),
		.root     (sq_root)
	);

	cgc_datapath #(
		.MaxStations (MaxStations)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_data         (in_data),
		.grid_width      (grid_width_q),
		.grid_height     (grid_height_q),
		.coverage_radius (radius_q),
		.sq_busy         (sq_busy),
		.sq_root         (sq_root),
		.radicand        (radicand),
		.out_data        (out_data)
	);

endmodule

`default_nettype wire

/* hw/rtl/cgc_isqrt.sv */
// Bit-serial integer square root, one root bit per cycle.
// Depends on cgc_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module cgc_isqrt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [cgc_pkg::SQ_W-1:0]   radicand,
	output logic                            busy,
	output logic [cgc_pkg::ROOT_W-1:0]      root
);

	logic                             busy_q;
	logic [cgc_pkg::ROOT_CNT_W-1:0]   bit_q;
	logic [cgc_pkg::SQ_W-1:0]         v_q;
	logic [cgc_pkg::ROOT_W-1:0]       s_q;
	logic [cgc_pkg::ROOT_W-1:0]       trial;
	logic [cgc_pkg::SQ_W-1:0]         trial_sq;

	assign trial    = s_q | (cgc_pkg::ROOT_W'(1) << bit_q);
	assign trial_sq = cgc_pkg::SQ_W'(trial) * cgc_pkg::SQ_W'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q == '0) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			s_q   <= '0;
			bit_q <= cgc_pkg::ROOT_CNT_W'(cgc_pkg::ROOT_W - 1);
		end else if (busy_q) begin
			if (trial_sq <= v_q) begin
				s_q <= trial;
			end
			bit_q <= bit_q - 1'b1;
		end
	end

	assign busy = busy_q;
	assign root = s_q;

`ifndef NO_ASSERTIONS
	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> (cgc_pkg::SQ_W'(s_q) * cgc_pkg::SQ_W'(s_q) <= v_q)
			&& ((17'(s_q) + 17'd1) * (17'(s_q) + 17'd1) > 17'(v_q)))
		else $error("square root result is not the floor root");
`endif

endmodule

`default_nettype wire

/* hw/rtl/cgc_ctrl.sv */
// Controller state machine: sequences clear sweeps, station lookup and the footprint walk.
// Depends on cgc_pkg for state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module cgc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire cgc_pkg::sts_t sts,
	output cgc_pkg::cmd_t      cmd
);

	cgc_pkg::state_t state_q, state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cgc_pkg::S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd         = '0;
		cmd.res_set = cgc_pkg::RES_NONE;
		in_ready    = 1'b0;
		state_d     = state_q;
		unique case (state_q)
			cgc_pkg::S_INIT: begin
				cmd.sweep_we = 1'b1;
				if (sts.sweep_last) state_d = cgc_pkg::S_IDLE;
			end
			cgc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_item = 1'b1;
					state_d        = cgc_pkg::S_DEC;
				end
			end
			cgc_pkg::S_DEC: begin
				priority if (sts.act == cgc_pkg::ACT_CLEAR) begin
					cmd.clr_tot = 1'b1;
					cmd.res_set = cgc_pkg::RES_ZERO;
					state_d     = cgc_pkg::S_CLEAR;
				end else if (!sts.idx_ok) begin
					cmd.res_set = cgc_pkg::RES_TOTALS;
					state_d     = cgc_pkg::S_DONE;
				end else begin
					cmd.st_rd = 1'b1;
					state_d   = cgc_pkg::S_SDEC;
				end
			end
			cgc_pkg::S_SDEC: begin
				if (sts.act == cgc_pkg::ACT_QUERY) begin
					cmd.res_set = cgc_pkg::RES_STATION;
					state_d     = cgc_pkg::S_DONE;
				end else begin
					cmd.setup = 1'b1;
					state_d   = sts.cols_empty ? cgc_pkg::S_FIN : cgc_pkg::S_DX;
				end
			end
			cgc_pkg::S_DX: begin
				cmd.dx  = 1'b1;
				state_d = cgc_pkg::S_SQSTART;
			end
			cgc_pkg::S_SQSTART: begin
				cmd.sq_start = 1'b1;
				state_d      = cgc_pkg::S_SQWAIT;
			end
			cgc_pkg::S_SQWAIT: begin
				if (!sts.sq_busy) begin
					cmd.rows = 1'b1;
					if (!sts.rows_empty) begin
						state_d = cgc_pkg::S_CRD;
					end else if (sts.col_last) begin
						state_d = cgc_pkg::S_FIN;
					end else begin
						cmd.next_col = 1'b1;
						state_d      = cgc_pkg::S_DX;
					end
				end
			end
			cgc_pkg::S_CRD: begin
				cmd.cell_rd = 1'b1;
				state_d     = cgc_pkg::S_CWR;
			end
			cgc_pkg::S_CWR: begin
				cmd.cell_wr = 1'b1;
				if (!sts.row_last) begin
					state_d = cgc_pkg::S_CRD;
				end else if (sts.col_last) begin
					state_d = cgc_pkg::S_FIN;
				end else begin
					cmd.next_col = 1'b1;
					state_d      = cgc_pkg::S_DX;
				end
			end
			cgc_pkg::S_FIN: begin
				cmd.res_set = cgc_pkg::RES_WALK;
				state_d     = cgc_pkg::S_DONE;
			end
			cgc_pkg::S_CLEAR: begin
				cmd.sweep_we = 1'b1;
				if (sts.sweep_last) state_d = cgc_pkg::S_DONE;
			end
			cgc_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = cgc_pkg::S_IDLE;
				end
			end
			default: state_d = cgc_pkg::S_INIT;
		endcase
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken beat");
`endif

endmodule

`default_nettype wire

/* hw/rtl/cgc_datapath.sv */
// Datapath: cell count store, station bit store, totals, footprint walk iterators.
// Depends on cgc_pkg; driven by cgc_ctrl commands, uses the root from cgc_isqrt.
`timescale 1ns / 1ps
`default_nettype none

module cgc_datapath #(
	parameter int MaxStations = cgc_pkg::MAX_STATIONS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire cgc_pkg::cmd_t                  cmd,
	output cgc_pkg::sts_t                       sts,
	input  wire cgc_pkg::in_t                   in_data,
	input  wire logic [cgc_pkg::GRID_W-1:0]     grid_width,
	input  wire logic [cgc_pkg::GRID_W-1:0]     grid_height,
	input  wire logic [cgc_pkg::RADIUS_W-1:0]   coverage_radius,
	input  wire logic                           sq_busy,
	input  wire logic [cgc_pkg::ROOT_W-1:0]     sq_root,
	output logic [cgc_pkg::SQ_W-1:0]            radicand,
	output cgc_pkg::out_t                       out_data
);

	// grid side is tied to the 8-bit site coordinates
	localparam int GRID_SIDE = cgc_pkg::MAX_GRID_SIDE_DEF;
	localparam int CELLS   = GRID_SIDE * GRID_SIDE;
	localparam int SWEEP_N = (CELLS > MaxStations) ? CELLS : MaxStations;
	localparam int SWP_W   = $clog2(SWEEP_N);
	localparam int CELL_AW = $clog2(CELLS);
	localparam int ST_AW   = $clog2(MaxStations);
	localparam int CRD_W   = cgc_pkg::CRD_W;

	// stores
	logic [cgc_pkg::CNT_W-1:0] cells_q [CELLS];
	logic                      stations_q [MaxStations];

	cgc_pkg::in_t                 item_q;
	logic [cgc_pkg::COV_W-1:0]    cov_tot_q, cov_q, cov_step;
	logic [cgc_pkg::USED_W-1:0]   used_tot_q, used_new;
	logic [SWP_W-1:0]             sweep_q;
	logic signed [CRD_W-1:0]      x_q, xe_q, y_q, ye_q;
	logic [cgc_pkg::SQ_W-1:0]     r2_q, dx2_q;
	logic [cgc_pkg::CNT_W-1:0]    cell_rd_q, cell_new;
	logic                         st_rd_q;
	cgc_pkg::out_t                res_q, out_q;

	logic [cgc_pkg::GRID_W-1:0]   w_eff, h_eff;
	logic signed [CRD_W-1:0]      sx_s, sy_s, r_s, span_s, w_m1, h_m1;
	logic signed [CRD_W-1:0]      x_lo, x_hi, x0, xe, y_lo, y_hi, y0, ye;
	logic signed [CRD_W-1:0]      dxs, dx_abs;
	logic [cgc_pkg::RADIUS_W-1:0] dx8;
	logic                         apply, add, commit, sweep_last;
	logic                         cell_we, st_we, st_wd;
	logic [CELL_AW-1:0]           cell_addr, cell_wa;
	logic [cgc_pkg::CNT_W-1:0]    cell_wd;
	logic [ST_AW-1:0]             st_addr, st_wa;

	// grid size clamp and footprint bounds
	assign w_eff = (32'(grid_width) > 32'(GRID_SIDE)) ?
		cgc_pkg::GRID_W'(GRID_SIDE) : grid_width;
	assign h_eff = (32'(grid_height) > 32'(GRID_SIDE)) ?
		cgc_pkg::GRID_W'(GRID_SIDE) : grid_height;
	assign w_m1  = $signed(CRD_W'(w_eff)) - $signed(CRD_W'(1));
	assign h_m1  = $signed(CRD_W'(h_eff)) - $signed(CRD_W'(1));
	assign sx_s  = $signed(CRD_W'(item_q.station_x));
	assign sy_s  = $signed(CRD_W'(item_q.station_y));
	assign r_s   = $signed(CRD_W'(coverage_radius));
	assign span_s = $signed(CRD_W'(sq_root));

	assign x_lo = sx_s - r_s;
	assign x_hi = sx_s + r_s;
	assign x0   = x_lo[CRD_W-1] ? '0 : x_lo;
	assign xe   = (x_hi > w_m1) ? w_m1 : x_hi;
	assign y_lo = sy_s - span_s;
	assign y_hi = sy_s + span_s;
	assign y0   = y_lo[CRD_W-1] ? '0 : y_lo;
	assign ye   = (y_hi > h_m1) ? h_m1 : y_hi;

	assign dxs    = x_q - sx_s;
	assign dx_abs = dxs[CRD_W-1] ? -dxs : dxs;
	assign dx8    = dx_abs[cgc_pkg::RADIUS_W-1:0];
	assign radicand = r2_q - dx2_q;

	assign apply  = (item_q.action == cgc_pkg::ACT_TOGGLE);
	assign add    = !st_rd_q;
	assign commit = (cmd.res_set == cgc_pkg::RES_WALK) && apply;
	assign used_new = st_rd_q ? used_tot_q - 1'b1 : used_tot_q + 1'b1;
	assign sweep_last = (32'(sweep_q) == 32'(SWEEP_N - 1));

	// one cell's read-modify-write
	always_comb begin
		cell_new = cell_rd_q;
		cov_step = cov_q;
		if (add) begin
			if (cell_rd_q == '0) cov_step = cov_q + 1'b1;
			if (cell_rd_q != cgc_pkg::CELL_MAX) cell_new = cell_rd_q + 1'b1;
		end else begin
			if (cell_rd_q == cgc_pkg::CNT_W'(1)) cov_step = cov_q - 1'b1;
			if (cell_rd_q != '0) cell_new = cell_rd_q - 1'b1;
		end
	end

	assign cell_addr = CELL_AW'($unsigned(x_q)) * CELL_AW'(GRID_SIDE)
		+ CELL_AW'($unsigned(y_q));
	assign cell_we = (cmd.sweep_we && (32'(sweep_q) < 32'(CELLS))) || (cmd.cell_wr && apply);
	assign cell_wa = cmd.sweep_we ? sweep_q[CELL_AW-1:0] : cell_addr;
	assign cell_wd = cmd.sweep_we ? '0 : cell_new;

	assign st_addr = ST_AW'(item_q.station_index);
	assign st_we   = (cmd.sweep_we && (32'(sweep_q) < 32'(MaxStations))) || commit;
	assign st_wa   = cmd.sweep_we ? sweep_q[ST_AW-1:0] : st_addr;
	assign st_wd   = cmd.sweep_we ? 1'b0 : !st_rd_q;

	always_ff @(posedge clk) begin
		if (cell_we) cells_q[cell_wa] <= cell_wd;
		if (cmd.cell_rd) cell_rd_q <= cells_q[cell_addr];
	end

	always_ff @(posedge clk) begin
		if (st_we) stations_q[st_wa] <= st_wd;
		if (cmd.st_rd) st_rd_q <= stations_q[st_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cov_tot_q  <= '0;
			used_tot_q <= '0;
			sweep_q    <= '0;
		end else begin
			if (cmd.clr_tot) begin
				cov_tot_q  <= '0;
				used_tot_q <= '0;
			end else if (commit) begin
				cov_tot_q  <= cov_q;
				used_tot_q <= used_new;
			end
			if (cmd.sweep_we) sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_item) item_q <= in_data;
		if (cmd.setup) begin
			x_q   <= x0;
			xe_q  <= xe;
			r2_q  <= cgc_pkg::SQ_W'(coverage_radius) * cgc_pkg::SQ_W'(coverage_radius);
			cov_q <= cov_tot_q;
		end
		if (cmd.dx) dx2_q <= cgc_pkg::SQ_W'(dx8) * cgc_pkg::SQ_W'(dx8);
		if (cmd.rows) begin
			y_q  <= y0;
			ye_q <= ye;
		end
		if (cmd.next_col) x_q <= x_q + $signed(CRD_W'(1));
		if (cmd.cell_wr) begin
			cov_q <= cov_step;
			y_q   <= y_q + $signed(CRD_W'(1));
		end
		case (cmd.res_set)
			cgc_pkg::RES_ZERO:    res_q <= '0;
			cgc_pkg::RES_TOTALS:  res_q <= '{cov_tot_q, used_tot_q, 1'b0};
			cgc_pkg::RES_STATION: res_q <= '{cov_tot_q, used_tot_q, st_rd_q};
			cgc_pkg::RES_WALK:    res_q <= '{cov_q, used_new, !st_rd_q};
			default:              res_q <= res_q;
		endcase
		if (cmd.load_out) out_q <= res_q;
	end

	always_comb begin
		sts            = '0;
		sts.act        = item_q.action;
		sts.idx_ok     = (32'(item_q.station_index) < 32'(MaxStations));
		sts.cols_empty = (x0 > xe);
		sts.sq_busy    = sq_busy;
		sts.rows_empty = (y0 > ye);
		sts.col_last   = (x_q == xe_q);
		sts.row_last   = (y_q == ye_q);
		sts.sweep_last = sweep_last;
	end

	assign out_data = out_q;

`ifndef NO_ASSERTIONS
	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cell_rd |-> (y_q <= ye_q) && (x_q <= xe_q) && !x_q[CRD_W-1] && !y_q[CRD_W-1])
		else $error("cell access outside the clipped footprint");
	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (used_tot_q == $past(used_tot_q) + cgc_pkg::USED_W'(1))
			|| (used_tot_q == $past(used_tot_q) - cgc_pkg::USED_W'(1)))
		else $error("station total moved by other than one");
`endif

endmodule

`default_nettype wire
